FILE: hw/rtl/imm_pkg.sv
package imm_pkg;

   localparam int DATA_W  = 32;
   localparam int FIELD_W = 3;
   localparam int CFG_W   = 4;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0]                operation;
      logic [FIELD_W-1:0]        row_index;
      logic [FIELD_W-1:0]        col_index;
      logic signed [DATA_W-1:0]  element_value;
   } imm_req_type;

   typedef struct packed {
      logic [FIELD_W-1:0]        out_row;
      logic [FIELD_W-1:0]        out_col;
      logic signed [DATA_W-1:0]  product_value;
      logic                      last;
   } imm_rsp_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic acc_clear;
      logic issue;
      logic out_load;
      logic out_last;
   } imm_cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } imm_status_type;

endpackage

FILE: hw/rtl/integer_matrix_multiply.sv
// Integer matrix multiplier. Load transactions (write A, write B) write one element of
// the selected MAX_DIM x MAX_DIM store; indexes at or above MAX_DIM are dropped. A
// compute transaction streams C = A x B in row-major order on the rsp channel, last
// set on the final element, results wrapped to 32 bits. Each product element takes one
// read of each store per step through their single read ports, then the registered
// multiplier and accumulator drain. The output register lets the next element start
// while a result waits; req_stall stays high until the whole product has been issued.
// Sizes are set through csr writes; the user must write them only while the block is
// idle, which the block itself does not enforce; values above MAX_DIM act as MAX_DIM.
module integer_matrix_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  imm_pkg::imm_req_type      req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output imm_pkg::imm_rsp_type      rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [imm_pkg::CFG_W-1:0] csr_data
);
   import imm_pkg::*;

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   imm_cmd_type    cmd;
   imm_status_type status;
   logic [IDX_W-1:0] row_i, col_j, step_k;

   imm_controller #(
      .MAX_DIM (MAX_DIM),
      .IDX_W   (IDX_W)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .operation (req_data.operation),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .row_i     (row_i),
      .col_j     (col_j),
      .step_k    (step_k)
   );

   imm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX_W      (IDX_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .row_i     (row_i),
      .col_j     (col_j),
      .step_k    (step_k),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/imm_controller.sv
module imm_controller #(
   parameter int MAX_DIM = 8,
   parameter int IDX_W   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                operation,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [imm_pkg::CFG_W-1:0] csr_data,
   output imm_pkg::imm_cmd_type      cmd,
   input  imm_pkg::imm_status_type   status,
   output logic [IDX_W-1:0]          row_i,
   output logic [IDX_W-1:0]          col_j,
   output logic [IDX_W-1:0]          step_k
);
   import imm_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DIM_W-1:0]   nr, nk, nc;
   logic               k_last, j_last, elem_last, start, emit;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v > CFG_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = DIM_W'(v);
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_ROWS_A) rows_a_ff <= csr_data;
         if (csr_index == CSR_INNER_DIM) inner_dim_ff <= csr_data;
         if (csr_index == CSR_COLS_B) cols_b_ff <= csr_data;
      end
   end

   assign nr = clamp_dim(rows_a_ff);
   assign nk = clamp_dim(inner_dim_ff);
   assign nc = clamp_dim(cols_b_ff);

   assign k_last    = (DIM_W'(k_ff) + 1'b1) == nk;
   assign j_last    = (DIM_W'(j_ff) + 1'b1) == nc;
   assign elem_last = j_last && ((DIM_W'(i_ff) + 1'b1) == nr);
   assign start     = req_valid && (operation == OP_COMPUTE) && (nr != '0) && (nc != '0);
   assign emit      = !status.busy && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = (nk == '0) ? ST_DRAIN : ST_ISSUE;
         end
         ST_ISSUE: begin
            if (k_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (emit) begin
               if (elem_last) state_in = ST_IDLE;
               else state_in = (nk == '0) ? ST_DRAIN : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.load_a = req_valid && (operation == OP_WRITE_A);
            cmd.load_b = req_valid && (operation == OP_WRITE_B);
            if (start) begin
               cmd.acc_clear = 1'b1;
               i_in = '0;
               j_in = '0;
               k_in = '0;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            k_in = k_last ? '0 : k_ff + 1'b1;
         end
         ST_DRAIN: begin
            if (emit) begin
               cmd.out_load  = 1'b1;
               cmd.out_last  = elem_last;
               cmd.acc_clear = 1'b1;
               if (j_last) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign row_i  = i_ff;
   assign col_j  = j_ff;
   assign step_k = k_ff;

endmodule

FILE: hw/rtl/imm_datapath.sv
module imm_datapath #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 32,
   parameter int IDX_W      = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  imm_pkg::imm_req_type    req_data,
   input  imm_pkg::imm_cmd_type    cmd,
   output imm_pkg::imm_status_type status,
   input  logic [IDX_W-1:0]        row_i,
   input  logic [IDX_W-1:0]        col_j,
   input  logic [IDX_W-1:0]        step_k,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output imm_pkg::imm_rsp_type    rsp_data
);
   import imm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ELEM_WIDTH-1:0]          a_mem_ff [DEPTH];
   logic [ELEM_WIDTH-1:0]          b_mem_ff [DEPTH];
   logic signed [ELEM_WIDTH-1:0]   a_rd_ff, b_rd_ff;
   logic                           rd_valid_ff, mul_valid_ff, rsp_valid_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_full;
   logic [DATA_W-1:0]              prod_ff, prod_in, acc_ff, acc_in;
   imm_rsp_type                    rsp_data_ff;
   logic                           wr_ok;
   logic [ADDR_W-1:0]              wr_addr, a_addr, b_addr;

   assign wr_ok = ({1'b0, req_data.row_index} < (FIELD_W + 1)'(MAX_DIM)) &&
                  ({1'b0, req_data.col_index} < (FIELD_W + 1)'(MAX_DIM));
   assign wr_addr = ADDR_W'(req_data.row_index) * ADDR_W'(MAX_DIM) +
                    ADDR_W'(req_data.col_index);
   assign a_addr = ADDR_W'(row_i) * ADDR_W'(MAX_DIM) + ADDR_W'(step_k);
   assign b_addr = ADDR_W'(step_k) * ADDR_W'(MAX_DIM) + ADDR_W'(col_j);

   always_ff @(posedge clock) begin
      if (cmd.load_a && wr_ok) a_mem_ff[wr_addr] <= req_data.element_value[ELEM_WIDTH-1:0];
      if (cmd.load_b && wr_ok) b_mem_ff[wr_addr] <= req_data.element_value[ELEM_WIDTH-1:0];
      if (cmd.issue) begin
         a_rd_ff <= a_mem_ff[a_addr];
         b_rd_ff <= b_mem_ff[b_addr];
      end
   end

   assign prod_full = a_rd_ff * b_rd_ff;
   assign prod_in   = DATA_W'(prod_full);
   assign acc_in    = cmd.acc_clear ? '0 : (mul_valid_ff ? acc_ff + prod_ff : acc_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.issue;
         mul_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff.out_row       <= FIELD_W'(row_i);
         rsp_data_ff.out_col       <= FIELD_W'(col_j);
         rsp_data_ff.product_value <= acc_ff;
         rsp_data_ff.last          <= cmd.out_last;
      end
   end

   assign status.busy     = rd_valid_ff || mul_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

FILE: hw/rtl/imm_checker.sv
module imm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input imm_pkg::imm_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input imm_pkg::imm_rsp_type rsp_data
);
   import imm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled rsp transaction dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled rsp payload changed");

   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.operation == OP_WRITE_A || req_data.operation == OP_WRITE_B)
      |=> !req_stall)
      else $error("load transaction left the block busy");

   a_rsp_from_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result produced outside a compute run");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
